// ===== sv/lifo_pal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack with palindrome check: shared package
// Operation and status codes, controller states, widths and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package lifo_pal_pkg;

   localparam int WORD_W        = 32;
   localparam int KIND_W        = 2;
   localparam int STATUS_W      = 2;
   localparam int FILL_W        = 9;
   localparam int CAP_W         = 9;
   localparam int DEPTH_DEFAULT = 256;
   localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH  = 2'd0,
      KIND_POP   = 2'd1,
      KIND_CHECK = 2'd2
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_DONE,
      S_CHK_LO,
      S_CHK_HI,
      S_CHK_CMP
   } state_type;

   typedef enum logic [1:0] {
      RD_TOP,
      RD_LO,
      RD_HI
   } rd_sel_type;

   typedef enum logic [1:0] {
      POP_ZERO,
      POP_MEM,
      POP_NEG1
   } pop_sel_type;

   // Controller to datapath
   typedef struct packed {
      logic        push_wr;
      logic        pop_dec;
      logic        clr_count;
      logic        rd_en;
      rd_sel_type  rd_sel;
      logic        chk_init;
      logic        chk_step;
      logic        cap_lo;
      logic        res_load;
      status_type  res_status;
      pop_sel_type res_pop;
      logic        res_pal;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic full;
      logic empty;
      logic short_stack;
      logic more_pairs;
      logic pair_match;
      logic slot_free;
   } stat_type;

endpackage

// ===== sv/lifo_pal_intf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack with palindrome check: channel interfaces
// Request, response and register-write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface lifo_pal_req_if import lifo_pal_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [KIND_W-1:0]        kind;
   logic signed [WORD_W-1:0] value;

   modport source (output valid, kind, value, input ready);
   modport sink   (input valid, kind, value, output ready);
endinterface

interface lifo_pal_rsp_if import lifo_pal_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [WORD_W-1:0] popped_value;
   logic [STATUS_W-1:0]      status;
   logic                     is_palindrome;
   logic [FILL_W-1:0]        fill_count;

   modport source (output valid, popped_value, status, is_palindrome, fill_count,
                   input ready);
   modport sink   (input valid, popped_value, status, is_palindrome, fill_count,
                   output ready);
endinterface

interface lifo_pal_csr_if import lifo_pal_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== sv/lifo_pal_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack with palindrome check: controller
// Sequences push, pop and the pairwise check walk over the datapath.
// ----------------------------------------------------------------------------
module lifo_pal_ctrl import lifo_pal_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [KIND_W-1:0] req_kind,
   output logic              req_ready,
   input  stat_type          stat,
   output cmd_type           cmd
);

   state_type state_ff;
   state_type state_in;
   logic      accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.rd_sel     = RD_TOP;
      cmd.res_status = ST_OK;
      cmd.res_pop    = POP_ZERO;
      req_ready      = 1'b0;
      accept         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            // hold ready low while in reset so no beat is taken and dropped
            req_ready = stat.slot_free && !reset;
            accept    = req_valid && req_ready;
            if (accept) begin
               unique case (kind_type'(req_kind))
                  KIND_PUSH: begin
                     cmd.res_load = 1'b1;
                     if (stat.full) begin
                        cmd.res_status = ST_OVERFLOW;
                     end else begin
                        cmd.push_wr = 1'b1;
                     end
                  end
                  KIND_POP: begin
                     if (stat.empty) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_UNDERFLOW;
                        cmd.res_pop    = POP_NEG1;
                     end else begin
                        cmd.pop_dec = 1'b1;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_TOP;
                        state_in    = S_POP_DONE;
                     end
                  end
                  KIND_CHECK: begin
                     if (stat.short_stack) begin
                        cmd.res_load  = 1'b1;
                        cmd.res_pal   = 1'b1;
                        cmd.clr_count = 1'b1;
                     end else begin
                        cmd.chk_init = 1'b1;
                        state_in     = S_CHK_LO;
                     end
                  end
                  default: begin
                     cmd.res_load = 1'b1;
                  end
               endcase
            end
         end
         S_POP_DONE: begin
            cmd.res_load = 1'b1;
            cmd.res_pop  = POP_MEM;
            state_in     = S_IDLE;
         end
         S_CHK_LO: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LO;
            state_in   = S_CHK_HI;
         end
         S_CHK_HI: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_HI;
            cmd.cap_lo = 1'b1;
            state_in   = S_CHK_CMP;
         end
         S_CHK_CMP: begin
            if (stat.pair_match && stat.more_pairs) begin
               cmd.chk_step = 1'b1;
               state_in     = S_CHK_LO;
            end else begin
               // stop at the first mismatch or after the innermost pair
               cmd.res_load  = 1'b1;
               cmd.res_pal   = stat.pair_match;
               cmd.clr_count = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/lifo_pal_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack with palindrome check: datapath
// Entry memory, fill count, capacity register, check pointers and the
// registered result beat.
// ----------------------------------------------------------------------------
module lifo_pal_dp import lifo_pal_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic                     csr_valid,
   input  logic [CAP_W-1:0]         csr_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [WORD_W-1:0] rsp_popped_value,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic                     rsp_is_palindrome,
   output logic [FILL_W-1:0]        rsp_fill_count
);

   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
   localparam int XW   = (CMPW > FILL_W) ? CMPW : FILL_W;
   localparam logic [CMPW-1:0] DEPTH_C = CMPW'(DEPTH);

   logic [WORD_W-1:0]        mem [DEPTH];
   logic [WORD_W-1:0]        rd_data_ff;
   logic [WORD_W-1:0]        lo_data_ff;
   logic [AW-1:0]            rd_addr;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic [CW-1:0]            count_dec;
   logic [CAP_W-1:0]         capacity_ff;
   logic [AW-1:0]            lo_ff;
   logic [AW-1:0]            hi_ff;
   logic                     rsp_valid_ff;
   logic signed [WORD_W-1:0] popped_ff;
   logic [STATUS_W-1:0]      status_ff;
   logic                     pal_ff;
   logic [FILL_W-1:0]        fill_ff;
   logic [CMPW-1:0]          count_cmp;
   logic [XW-1:0]            count_fill;
   logic [WORD_W-1:0]        popped_in;

   assign count_dec  = count_ff - CW'(1);
   assign count_cmp  = CMPW'(count_ff);
   assign count_fill = XW'(count_in);

   // Status towards the controller
   always_comb begin
      stat.full        = (count_cmp >= CMPW'(capacity_ff)) || (count_cmp >= DEPTH_C);
      stat.empty       = (count_ff == '0);
      stat.short_stack = (count_ff <= CW'(1));
      stat.more_pairs  = ((AW + 1)'(lo_ff) + (AW + 1)'(2)) < (AW + 1)'(hi_ff);
      stat.pair_match  = (lo_data_ff == rd_data_ff);
      stat.slot_free   = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      if (cmd.clr_count) begin
         count_in = '0;
      end else if (cmd.push_wr) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop_dec) begin
         count_in = count_dec;
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      case (cmd.rd_sel)
         RD_LO:   rd_addr = lo_ff;
         RD_HI:   rd_addr = hi_ff;
         default: rd_addr = count_dec[AW-1:0];
      endcase
   end

   always_comb begin
      case (cmd.res_pop)
         POP_MEM:  popped_in = rd_data_ff;
         POP_NEG1: popped_in = '1;
         default:  popped_in = '0;
      endcase
   end

   // Entry memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (cmd.push_wr) begin
         mem[count_ff[AW-1:0]] <= req_value;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         capacity_ff  <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (csr_valid) begin
            capacity_ff <= csr_data;
         end
         if (cmd.res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Check pointers and result payload
   always_ff @(posedge clock) begin
      if (cmd.chk_init) begin
         lo_ff <= '0;
         hi_ff <= count_dec[AW-1:0];
      end else if (cmd.chk_step) begin
         lo_ff <= lo_ff + AW'(1);
         hi_ff <= hi_ff - AW'(1);
      end
      if (cmd.cap_lo) begin
         lo_data_ff <= rd_data_ff;
      end
      if (cmd.res_load) begin
         popped_ff <= popped_in;
         status_ff <= cmd.res_status;
         pal_ff    <= cmd.res_pal;
         fill_ff   <= count_fill[FILL_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_popped_value  = popped_ff;
   assign rsp_status        = status_ff;
   assign rsp_is_palindrome = pal_ff;
   assign rsp_fill_count    = fill_ff;

endmodule

// ===== sv/lifo_stack_with_palindrome_check.sv =====
`timescale 1ns / 1ps
// Push, no-op, empty pop and a check of at most one entry load their beat in the cycle
//   after acceptance; a pop with data reads the top entry, then loads it in S_POP_DONE.
// A check of n entries runs S_CHK_LO, S_CHK_HI and S_CHK_CMP for each pair compared,
//   at most floor(n/2), as the memory has one read port; it stops at the first mismatch.
// One push per cycle while responses drain; a pop stalls requests until its beat loads.
// Reset clears the fill count and sets capacity to 256; memory contents are kept.
// ----------------------------------------------------------------------------
// LIFO stack with palindrome check: top level
// Bounded stack of signed words with run-time capacity, pop underflow and
// push overflow flags, and a palindrome check that empties the stack.
// ----------------------------------------------------------------------------
module lifo_stack_with_palindrome_check import lifo_pal_pkg::*; #(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   lifo_pal_req_if.sink   req_chan,
   lifo_pal_rsp_if.source rsp_chan,
   lifo_pal_csr_if.sink   csr_chan
);

   cmd_type  cmd;
   stat_type stat;

   // Capacity writes are registered directly, so take the beat whenever out of reset
   assign csr_chan.ready = !reset;

   // Controller: decode the request kind, walk the check, steer the result
   lifo_pal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_kind  (req_chan.kind),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Datapath: hold entries, fill count, capacity and the result beat
   lifo_pal_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_value         (req_chan.value),
      .csr_valid         (csr_chan.valid),
      .csr_data          (csr_chan.data),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_popped_value  (rsp_chan.popped_value),
      .rsp_status        (rsp_chan.status),
      .rsp_is_palindrome (rsp_chan.is_palindrome),
      .rsp_fill_count    (rsp_chan.fill_count)
   );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO stack with palindrome check: self-checking testbench
// Drives push, pop, check and unused-kind beats through the request channel,
// rewrites the capacity register between phases, and compares every response
// beat against an in-bench stack mirror. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench import lifo_pal_pkg::*; ();

   localparam int STACK_DEPTH = DEPTH_DEFAULT;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int TAIL_CYCLES = 400;   // longer than a full-depth check
   localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;   // unused code, no effect

   // One response beat as the block should produce it
   typedef struct packed {
      logic signed [WORD_W-1:0] popped;
      status_type               status;
      logic                     pal;
      logic [FILL_W-1:0]        fill;
   } stack_outcome_type;

   typedef enum logic { ROW_OP, ROW_CAP } row_kind_type;

   // One row of the directed plan: a beat, or a capacity write (in value)
   typedef struct packed {
      row_kind_type             what;
      logic [KIND_W-1:0]        kind;
      logic signed [WORD_W-1:0] value;
      logic                     typed;
      stack_outcome_type        want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lifo_pal_req_if req_if ();
   lifo_pal_rsp_if rsp_if ();
   lifo_pal_csr_if csr_if ();

   lifo_stack_with_palindrome_check #(.DEPTH(STACK_DEPTH)) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stack mirror: entries, fill and the capacity last written
   logic signed [WORD_W-1:0] stack_words [STACK_DEPTH];
   int unsigned              stack_fill      = 0;
   logic [CAP_W-1:0]         capacity_mirror = CAP_RESET;

   stack_outcome_type pending_outcomes [$];   // responses still owed, oldest first
   int                mismatch_count = 0;
   int                ops_issued     = 0;
   int                cycle_count    = 0;
   bit                idle_on        = 1'b1;  // random gaps and stalls when set

   // ------------------------------------------------------------------------
   // Stack mirror: apply one accepted beat and return the response it owes.
   // ------------------------------------------------------------------------
   function automatic stack_outcome_type stack_apply(input logic [KIND_W-1:0] kind,
                                                     input logic signed [WORD_W-1:0] value);
      stack_outcome_type o;
      int unsigned       lim;
      int unsigned       lo;
      int unsigned       hi;
      bit                same;
      o = '0;
      o.status = ST_OK;
      // capacity above the storage depth is clipped to the depth
      lim = 32'(capacity_mirror);
      if (lim > STACK_DEPTH) lim = STACK_DEPTH;
      case (kind)
         KIND_PUSH: begin
            // full (or capacity lowered under the fill): drop the word
            if (stack_fill >= lim) begin
               o.status = ST_OVERFLOW;
            end else begin
               stack_words[stack_fill] = value;
               stack_fill++;
            end
         end
         KIND_POP: begin
            if (stack_fill == 0) begin
               o.popped = -1;
               o.status = ST_UNDERFLOW;
            end else begin
               stack_fill--;
               o.popped = stack_words[stack_fill];
            end
         end
         KIND_CHECK: begin
            // walk inward from both ends; an empty stack counts as symmetric
            same = 1'b1;
            lo = 0;
            hi = stack_fill;
            while (lo + 1 < hi) begin
               hi--;
               if (stack_words[lo] != stack_words[hi]) same = 1'b0;
               lo++;
            end
            o.pal = same;
            stack_fill = 0;
         end
         default: ;   // unused kind: nothing moves
      endcase
      o.fill = stack_fill[FILL_W-1:0];
      return o;
   endfunction

   // Mostly short pauses, now and then a long one
   function automatic int pause_len();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(12, 40);
   endfunction

   // Words: small values make accidental matches likely, extremes hit the edges
   function automatic logic signed [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 3);
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return -1;
               default: return 0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic bit field_ok(input string name, input logic [31:0] want,
                                   input logic [31:0] seen);
      if (seen !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, seen);
         return 1'b0;
      end
      return 1'b1;
   endfunction

   // Directed plan rows
   function automatic plan_row_type step_row(input logic [KIND_W-1:0] kind,
                                             input logic signed [WORD_W-1:0] value);
      plan_row_type r;
      r = '0;
      r.what  = ROW_OP;
      r.kind  = kind;
      r.value = value;
      return r;
   endfunction

   function automatic plan_row_type known_row(input logic [KIND_W-1:0] kind,
                                              input logic signed [WORD_W-1:0] value,
                                              input logic signed [WORD_W-1:0] popped,
                                              input status_type status,
                                              input logic pal,
                                              input logic [FILL_W-1:0] fill);
      plan_row_type r;
      r = step_row(kind, value);
      r.typed       = 1'b1;
      r.want.popped = popped;
      r.want.status = status;
      r.want.pal    = pal;
      r.want.fill   = fill;
      return r;
   endfunction

   function automatic plan_row_type capacity_row(input logic [CAP_W-1:0] cap);
      plan_row_type r;
      r = '0;
      r.what  = ROW_CAP;
      r.value = WORD_W'(cap);
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side. Every task starts and ends on a rising edge; valid is held
   // high between back-to-back beats and dropped only for a gap or a capacity write.
   // ------------------------------------------------------------------------
   task automatic issue_op(input logic [KIND_W-1:0] kind,
                           input logic signed [WORD_W-1:0] value,
                           input logic typed, input stack_outcome_type want);
      stack_outcome_type predicted;
      int                gap;
      gap = (idle_on && $urandom_range(0, 3) == 0) ? pause_len() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.kind  <= kind;
      req_if.value <= value;
      do @(posedge clock); while (!req_if.ready);
      // accepted at this edge: advance the mirror and queue the owed beat
      predicted = stack_apply(kind, value);
      pending_outcomes.push_back(typed ? want : predicted);
      ops_issued++;
   endtask

   task automatic send(input logic [KIND_W-1:0] kind, input logic signed [WORD_W-1:0] value);
      issue_op(kind, value, 1'b0, '0);
   endtask

   task automatic wait_drained();
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Hold requests off until every owed beat is back, then write capacity.
   // Every beat gives a response, so an empty queue means the block is idle.
   task automatic set_capacity(input logic [CAP_W-1:0] cap);
      req_if.valid <= 1'b0;
      @(posedge clock);
      wait_drained();
      csr_if.valid <= 1'b1;
      csr_if.data  <= cap;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid    <= 1'b0;
      capacity_mirror = cap;
   endtask

   // Clear, push a mirrored sequence (optionally with one spoiled word on the
   // lower half, so its partner can never match), maybe one more push, check.
   task automatic palindrome_run(input int len, input bit spoil, input bit extra);
      logic signed [WORD_W-1:0] half [$];
      logic signed [WORD_W-1:0] word;
      int                       pos;
      int                       i;
      send(KIND_CHECK, pick_word());
      for (i = 0; i < (len + 1) / 2; i++) half.push_back(pick_word());
      pos = (spoil && len >= 2) ? int'($urandom_range(0, len / 2 - 1)) : -1;
      for (i = 0; i < len; i++) begin
         word = (i < (len + 1) / 2) ? half[i] : half[len - 1 - i];
         if (i == pos) word = word ^ (32'h1 << $urandom_range(0, 31));
         send(KIND_PUSH, word);
      end
      if (extra) send(KIND_PUSH, pick_word());
      send(KIND_CHECK, pick_word());
   endtask

   // Push until one push overflows, at most a couple of dozen beats
   task automatic push_to_full(input int unsigned lim);
      int room;
      room = int'(lim) - int'(stack_fill) + 1;
      if (room < 1) room = 1;
      repeat ((room > 24) ? 24 : room) send(KIND_PUSH, pick_word());
   endtask

   task automatic run_phase(input logic [CAP_W-1:0] cap, input int budget,
                            input bit end_full, input bit idle);
      int unsigned lim;
      int          stop_at;
      idle_on = idle;
      set_capacity(cap);
      lim = 32'(cap);
      if (lim > STACK_DEPTH) lim = STACK_DEPTH;
      stop_at = ops_issued + budget;
      while (ops_issued < stop_at) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: palindrome_run(int'($urandom_range(0, (lim < 10) ? lim + 1 : 10)),
                                       $urandom_range(0, 2) == 0,
                                       $urandom_range(0, 3) == 0);
            4, 5: repeat ($urandom_range(1, 10))
                     send($urandom_range(0, 1) ? KIND_PUSH : KIND_POP, pick_word());
            6: push_to_full(lim);
            // pop one past empty to hit underflow, draining at most 24 entries
            7: repeat (((stack_fill > 24) ? 24 : stack_fill) + 1) send(KIND_POP, $urandom);
            // noise: any kind, unused code included, any word
            8: repeat ($urandom_range(1, 4)) send(KIND_W'($urandom_range(0, 3)), $urandom);
            default: send(KIND_CHECK, $urandom);
         endcase
      end
      if (end_full) push_to_full(lim);
   endtask

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      plan_row_type directed_plan [$];
      req_if.valid <= 1'b0;
      req_if.kind  <= KIND_PUSH;
      req_if.value <= '0;
      csr_if.valid <= 1'b0;
      csr_if.data  <= CAP_RESET;

      directed_plan = '{
         // straight after reset: empty stack, capacity at its reset value
         known_row(KIND_POP,   0,            -1, ST_UNDERFLOW, 1'b0, 9'd0),
         known_row(KIND_CHECK, 0,             0, ST_OK,        1'b1, 9'd0),
         known_row(KIND_NOP,   -1,            0, ST_OK,        1'b0, 9'd0),
         // word extremes in, then back out in reverse order
         known_row(KIND_PUSH,  32'h7FFF_FFFF, 0, ST_OK,        1'b0, 9'd1),
         known_row(KIND_PUSH,  32'h8000_0000, 0, ST_OK,        1'b0, 9'd2),
         known_row(KIND_PUSH,  0,             0, ST_OK,        1'b0, 9'd3),
         known_row(KIND_PUSH,  -1,            0, ST_OK,        1'b0, 9'd4),
         known_row(KIND_NOP,   32'h5A5A_A5A5, 0, ST_OK,        1'b0, 9'd4),
         // a stored -1 pops with status ok, unlike underflow
         known_row(KIND_POP,   0,            -1, ST_OK,        1'b0, 9'd3),
         step_row(KIND_POP,    0),
         step_row(KIND_POP,    -1),
         step_row(KIND_POP,    0),
         known_row(KIND_POP,   0,            -1, ST_UNDERFLOW, 1'b0, 9'd0),
         // capacity of one: second push overflows; one entry is symmetric
         capacity_row(9'd1),
         known_row(KIND_PUSH,  5,             0, ST_OK,        1'b0, 9'd1),
         known_row(KIND_PUSH,  6,             0, ST_OVERFLOW,  1'b0, 9'd1),
         known_row(KIND_CHECK, 0,             0, ST_OK,        1'b1, 9'd0),
         // capacity of zero: every push overflows
         capacity_row(9'd0),
         known_row(KIND_PUSH,  7,             0, ST_OVERFLOW,  1'b0, 9'd0),
         // odd-length palindrome at capacity
         capacity_row(9'd3),
         step_row(KIND_PUSH,   1),
         step_row(KIND_PUSH,   2),
         step_row(KIND_PUSH,   1),
         step_row(KIND_CHECK,  0),
         // capacity lowered under the fill: push overflows, contents stay
         step_row(KIND_PUSH,   4),
         step_row(KIND_PUSH,   8),
         capacity_row(9'd1),
         known_row(KIND_PUSH,  3,             0, ST_OVERFLOW,  1'b0, 9'd2),
         known_row(KIND_CHECK, 0,             0, ST_OK,        1'b0, 9'd0)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_plan[i]) begin
         if (directed_plan[i].what == ROW_CAP) begin
            set_capacity(directed_plan[i].value[CAP_W-1:0]);
         end else begin
            issue_op(directed_plan[i].kind, directed_plan[i].value,
                     directed_plan[i].typed, directed_plan[i].want);
         end
      end

      // Capacity above depth: fill every entry with a palindrome, overflow
      // once at full depth, then check the whole store
      idle_on = 1'b1;
      set_capacity(9'd511);
      palindrome_run(STACK_DEPTH, 1'b0, 1'b1);

      // Random phases; idling is off in some of them so those stretches run flat out.
      // Capacity drops below the fill left by the phase before it in places.
      run_phase(9'd511, 10, 1'b0, 1'b0);
      run_phase(9'd6,   12, 1'b1, 1'b1);
      run_phase(9'd2,   10, 1'b0, 1'b0);
      run_phase(9'd256, 12, 1'b0, 1'b1);
      run_phase(9'd1,   10, 1'b0, 1'b1);
      run_phase(9'd0,   10, 1'b0, 1'b0);
      run_phase(9'd17,  12, 1'b1, 1'b1);
      run_phase(9'd3,   10, 1'b0, 1'b1);
      run_phase(9'd300, 12, 1'b0, 1'b0);

      // Drop valid, collect what is owed, then watch for stray beats
      req_if.valid <= 1'b0;
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("[lifo_stack_with_palindrome_check] OK");
      end else begin
         $display("[lifo_stack_with_palindrome_check] ERROR");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side: check each accepted beat against the oldest owed one,
   // then choose ready for the next edge (random stalls when idling is on).
   // ------------------------------------------------------------------------
   initial begin : response_side
      stack_outcome_type want;
      int                stall_left;
      bit                ok;
      stall_left = 0;
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_outcomes.size() == 0) begin
               $display("%0t: response beat with none expected, actual %h %h %h %h",
                        $time, rsp_if.popped_value, rsp_if.status,
                        rsp_if.is_palindrome, rsp_if.fill_count);
               mismatch_count++;
            end else begin
               want = pending_outcomes.pop_front();
               ok = field_ok("popped_value", want.popped, rsp_if.popped_value);
               ok = field_ok("status", 32'(want.status), 32'(rsp_if.status)) && ok;
               ok = field_ok("is_palindrome", 32'(want.pal),
                             32'(rsp_if.is_palindrome)) && ok;
               ok = field_ok("fill_count", 32'(want.fill), 32'(rsp_if.fill_count)) && ok;
               if (!ok) mismatch_count++;
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = pause_len() - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("[lifo_stack_with_palindrome_check] ERROR");
         $finish;
      end
   end

endmodule
